// ===== sv/mrbr_pkg.sv =====
// ---------------------------------------------------------------------------
// mrbr_pkg
// shared types and codes of the broadcast ring: opcodes, status codes and
// the packing of the input and result beats
// ---------------------------------------------------------------------------
package mrbr_pkg;

  localparam int OPCODE_W = 3;
  localparam int SLOT_W   = 3;
  localparam int WORD_W   = 32;
  localparam int LIMIT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int DLV_W    = 5;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_APPEND      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUBSCRIBE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_UNSUBSCRIBE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CONSUME     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ACK         = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_READER = 2'd3;

  // input tdata, first member in the top bits
  typedef struct packed {
    logic [LIMIT_W-1:0] burst_limit;
    logic [WORD_W-1:0]  event_word;
    logic [SLOT_W-1:0]  reader_slot;
  } in_data_t;

  // result tdata, zero padded to whole bytes
  typedef struct packed {
    logic [5:0]          pad;
    logic [DLV_W-1:0]    delivered;
    logic [WORD_W-1:0]   out_event;
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
  } out_data_t;

  // one result beat as held in the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [WORD_W-1:0]   out_event;
    logic                has_event;
    logic [DLV_W-1:0]    delivered;
    logic                last;
  } out_beat_t;

endpackage

// ===== sv/mrbr_ram.sv =====
// ---------------------------------------------------------------------------
// mrbr_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module mrbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/multi_reader_broadcast_ring.sv =====
// ---------------------------------------------------------------------------
// multi_reader_broadcast_ring
// broadcast ring buffer: one writer, several readers with own read pointers
// ---------------------------------------------------------------------------
// an item that gives one result passes accept, then execute, which waits
//   for a free output register; its result sits there from the cycle after execute
// consume of n events: events leave at one per cycle while the result channel
//   takes them, paced by the single read port of the event memory (issue, read, output register)
// the input is ready only in idle: a new item waits until the last one, a consume with all its events, is done
// reset: synchronous, clears write pointer, read pointers and reader flags;
//   the event memory is not cleared and needs no clearing pass
module multi_reader_broadcast_ring #(
  parameter int CAPACITY    = 64,
  parameter int READERS     = 8,
  parameter int EVENT_WIDTH = 32,
  parameter int MAX_BURST   = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [$bits(mrbr_pkg::in_data_t)-1:0]   in_tdata,  // reader_slot, event_word, burst_limit
  input  logic [mrbr_pkg::OPCODE_W-1:0]           in_tuser,  // opcode
  // result channel
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [$bits(mrbr_pkg::out_data_t)-1:0]  out_tdata, // status, granted_slot, out_event, delivered, zeros
  output logic                                    out_tuser, // has_event
  output logic                                    out_tlast  // last
);

  // pointers count modulo twice the capacity, entry address is modulo capacity
  localparam int SPAN    = 2 * CAPACITY;
  localparam int PTR_W   = $clog2(SPAN);
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RIDX_W  = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int STORE_W = (EVENT_WIDTH < mrbr_pkg::WORD_W) ? EVENT_WIDTH : mrbr_pkg::WORD_W;
  localparam int DLV_W   = mrbr_pkg::DLV_W;

  localparam logic [PTR_W-1:0] CAP_P  = PTR_W'(CAPACITY);
  localparam logic [PTR_W-1:0] SPAN_P = PTR_W'(SPAN);   // zero when span is a power of two

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  // control state
  logic [1:0]         state_r, state_nxt;
  ptr_t               wp_r, wp_nxt;
  ptr_t               rp_r [READERS];
  ptr_t               rp_nxt [READERS];
  logic [READERS-1:0] active_r, active_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               rdv_r, rdv_nxt;            // ram read data holds an event
  ptr_t               rd_ptr_r, rd_ptr_nxt;      // next pointer to read
  logic [DLV_W-1:0]   issued_r, issued_nxt;      // reads issued so far
  logic [DLV_W-1:0]   rd_k_r, rd_k_nxt;          // event number in ram output
  logic [DLV_W-1:0]   n_r, n_nxt;                // events in this consume

  // backlog per reader, registered from the pointers every cycle
  ptr_t               bl_r [READERS];
  ptr_t               bl_nxt [READERS];

  // item and result payload
  logic [mrbr_pkg::OPCODE_W-1:0] op_r;
  logic [mrbr_pkg::SLOT_W-1:0]   slot_r;
  logic [STORE_W-1:0]            word_r;
  logic [mrbr_pkg::LIMIT_W-1:0]  limit_r;
  mrbr_pkg::out_beat_t           out_beat_r, out_beat_nxt;
  mrbr_pkg::in_data_t            in_data;
  mrbr_pkg::out_data_t           out_data;

  // event memory port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [STORE_W-1:0] ram_rdata;

  // decode helpers
  logic               accept;
  logic               out_can;
  logic               rd_move;
  logic               slot_ok;
  logic [RIDX_W-1:0]  sidx;
  logic               sel_active;
  ptr_t               sel_bl;
  logic [READERS-1:0] full_vec;
  logic               any_active;
  logic               any_full;
  logic               free_found;
  logic [RIDX_W-1:0]  free_idx;
  logic [mrbr_pkg::LIMIT_W-1:0] lim_eff;
  logic [DLV_W-1:0]   n_cons;
  logic [PTR_W:0]     rp_sum;
  ptr_t               rp_adv;

  assign in_data   = mrbr_pkg::in_data_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // output register frees when empty or drained this cycle
  assign out_can = !out_valid_r || out_tready;
  assign rd_move = rdv_r && out_can;

  // selected reader, a slot beyond the reader count reads as inactive
  assign slot_ok    = (int'(slot_r) < READERS);
  assign sidx       = RIDX_W'(slot_r);
  assign sel_active = slot_ok && active_r[sidx];
  assign sel_bl     = sel_active ? bl_r[sidx] : '0;

  // overflow: some active reader already a full capacity behind
  always_comb begin
    for (int i = 0; i < READERS; i++) begin
      full_vec[i] = (bl_r[i] >= CAP_P);
    end
  end
  assign any_active = |active_r;
  assign any_full   = |(active_r & full_vec);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = READERS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = RIDX_W'(i);
      end
    end
  end

  // events for a consume: min of backlog, burst limit and burst cap
  always_comb begin
    lim_eff = (int'(limit_r) > MAX_BURST) ? mrbr_pkg::LIMIT_W'(MAX_BURST) : limit_r;
    if (int'(sel_bl) < int'(lim_eff)) begin
      n_cons = DLV_W'(sel_bl);
    end else begin
      n_cons = DLV_W'(lim_eff);
    end
  end

  // reader pointer after the consume, wrapped into the pointer span
  assign rp_sum = {1'b0, rp_r[sidx]} + (PTR_W + 1)'(n_cons);
  assign rp_adv = (int'(rp_sum) >= SPAN) ? PTR_W'(rp_sum - (PTR_W + 1)'(SPAN))
                                         : PTR_W'(rp_sum);

  // backlog = write pointer minus read pointer, modulo the span
  always_comb begin
    for (int i = 0; i < READERS; i++) begin
      if (wp_r >= rp_r[i]) begin
        bl_nxt[i] = wp_r - rp_r[i];
      end else begin
        bl_nxt[i] = wp_r - rp_r[i] + SPAN_P;
      end
    end
  end

  // entry address of a pointer
  assign ram_waddr = (wp_r >= CAP_P) ? ADDR_W'(wp_r - CAP_P) : ADDR_W'(wp_r);
  assign ram_raddr = (rd_ptr_r >= CAP_P) ? ADDR_W'(rd_ptr_r - CAP_P) : ADDR_W'(rd_ptr_r);

  // main sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_beat_nxt  = out_beat_r;
    rdv_nxt       = rdv_r;
    rd_ptr_nxt    = rd_ptr_r;
    issued_nxt    = issued_r;
    rd_k_nxt      = rd_k_r;
    n_nxt         = n_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    for (int i = 0; i < READERS; i++) begin
      rp_nxt[i] = rp_r[i];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if ((op_r == mrbr_pkg::OP_CONSUME) && (n_cons != '0)) begin
          // commit the new pointer now, the events stream out afterwards
          rp_nxt[sidx] = rp_adv;
          rd_ptr_nxt   = rp_r[sidx];
          issued_nxt   = '0;
          n_nxt        = n_cons;
          state_nxt    = S_STREAM;
        end else if (out_can) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{status: mrbr_pkg::ST_OK, granted_slot: '0, out_event: '0,
                            has_event: 1'b0, delivered: '0, last: 1'b1};
          state_nxt     = S_IDLE;
          unique case (op_r)
            mrbr_pkg::OP_APPEND: begin
              if (!any_active) begin
                out_beat_nxt.status = mrbr_pkg::ST_NO_READER;
              end else if (any_full) begin
                out_beat_nxt.status = mrbr_pkg::ST_OVERFLOW;
              end else begin
                ram_we = 1'b1;
                wp_nxt = (int'(wp_r) == SPAN - 1) ? '0 : wp_r + 1'b1;
              end
            end
            mrbr_pkg::OP_SUBSCRIBE: begin
              if (free_found) begin
                active_nxt[free_idx]      = 1'b1;
                rp_nxt[free_idx]          = wp_r;
                out_beat_nxt.granted_slot = mrbr_pkg::SLOT_W'(free_idx);
              end else begin
                out_beat_nxt.status = mrbr_pkg::ST_NO_SLOT;
              end
            end
            mrbr_pkg::OP_UNSUBSCRIBE: begin
              if (slot_ok) begin
                active_nxt[sidx] = 1'b0;
                rp_nxt[sidx]     = '0;
              end
            end
            mrbr_pkg::OP_ACK: begin
              if (sel_active) begin
                rp_nxt[sidx] = wp_r;
              end
            end
            mrbr_pkg::OP_CLEAR: begin
              wp_nxt = '0;
              for (int i = 0; i < READERS; i++) begin
                if (active_r[i]) begin
                  rp_nxt[i] = '0;
                end
              end
            end
            default: begin
              // empty consume and unknown opcodes: plain final beat
            end
          endcase
        end
      end

      S_STREAM: begin
        // issue a read when the ram output is free or moves on this cycle
        if ((issued_r != n_r) && (!rdv_r || rd_move)) begin
          ram_re     = 1'b1;
          rdv_nxt    = 1'b1;
          rd_ptr_nxt = (int'(rd_ptr_r) == SPAN - 1) ? '0 : rd_ptr_r + 1'b1;
          issued_nxt = issued_r + 1'b1;
          rd_k_nxt   = issued_r + 1'b1;
        end else if (rd_move) begin
          rdv_nxt = 1'b0;
        end
        if (rd_move) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{status: mrbr_pkg::ST_OK, granted_slot: '0,
                            out_event: mrbr_pkg::WORD_W'(ram_rdata), has_event: 1'b1,
                            delivered: rd_k_r, last: (rd_k_r == n_r)};
          if (rd_k_r == n_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      rd_ptr_r    <= '0;
      issued_r    <= '0;
      rd_k_r      <= '0;
      n_r         <= '0;
      for (int i = 0; i < READERS; i++) begin
        rp_r[i] <= '0;
        bl_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= rdv_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      issued_r    <= issued_nxt;
      rd_k_r      <= rd_k_nxt;
      n_r         <= n_nxt;
      for (int i = 0; i < READERS; i++) begin
        rp_r[i] <= rp_nxt[i];
        bl_r[i] <= bl_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser;
      slot_r  <= in_data.reader_slot;
      word_r  <= in_data.event_word[STORE_W-1:0];
      limit_r <= in_data.burst_limit;
    end
    out_beat_r <= out_beat_nxt;
  end

  // event memory
  mrbr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (CAPACITY)
  ) u_event_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (word_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // result channel
  always_comb begin
    out_data              = '0;
    out_data.status       = out_beat_r.status;
    out_data.granted_slot = out_beat_r.granted_slot;
    out_data.out_event    = out_beat_r.out_event;
    out_data.delivered    = out_beat_r.delivered;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data;
  assign out_tuser  = out_beat_r.has_event;
  assign out_tlast  = out_beat_r.last;

`ifndef ASSERT_OFF
  // a beat without an event always closes its item
  a_plain_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("result without event not marked last");

  // event beats carry a nonzero running count
  a_event_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_beat_r.delivered != '0))
    else $error("event beat with zero delivered count");

  // a new read never overwrites an event still waiting in the ram output
  a_ram_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (!rdv_r || rd_move))
    else $error("ram read overwrote pending event");

  // an accepted item goes to execute on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == S_EXEC))
    else $error("accepted item not executed");
`endif

endmodule
